// ===== rtl/core/rgbmg_pkg.sv =====
// rgbmg_pkg: shared types, constants and state codes for the rgb magnitude core
// no dependencies
`timescale 1ns / 1ps
package rgbmg_pkg;
	localparam int MAX_PIXELS_DEF = 65536;
	localparam logic [7:0] BRIGHT_RST = 8'd255;
	localparam logic INVERT_RST = 1'b1;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;
	localparam logic REG_BRIGHT = 1'b0;
	localparam logic REG_INVERT = 1'b1;
	localparam int MAG_W = 17;
	localparam int SQ_W = 34;
	localparam int SQRT_STEPS = 17;
	localparam int DIV_STEPS = 17;
	localparam int NUM_W = 33;

	typedef struct packed {
		logic operation;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic frame_end;
	} in_item_t;

	typedef struct packed {
		logic [15:0] gray_value;
		logic last_pixel;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_SQRT, ST_STORE, ST_RDADDR, ST_RDDATA, ST_MUL, ST_DIV,
		ST_FINISH, ST_OUT
	} state_t;

	typedef struct packed {
		logic start_sq;
		logic sqrt_step;
		logic store;
		logic new_frame;
		logic rd_addr;
		logic rd_data;
		logic mul;
		logic div_step;
		logic finish;
		logic out_take;
	} cmd_t;

	typedef struct packed {
		logic frame_closed;
		logic can_read;
	} sts_t;
endpackage

// ===== rtl/core/rgbmg_ctrl.sv =====
// rgbmg_ctrl: sequencer for load (square root) and read (division) items
// depends on rgbmg_pkg
`timescale 1ns / 1ps
module rgbmg_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_op,
	input logic out_ready,
	input rgbmg_pkg::sts_t sts,
	output logic in_ready,
	output logic out_valid,
	output rgbmg_pkg::cmd_t cmd
);
	rgbmg_pkg::state_t state_q, state_d;
	logic [4:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgbmg_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			rgbmg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == rgbmg_pkg::OP_LOAD) begin
						cmd.start_sq = 1'b1;
						cmd.new_frame = sts.frame_closed;
						state_d = rgbmg_pkg::ST_SQ;
					end else if (sts.can_read) begin
						cmd.rd_addr = 1'b1;
						state_d = rgbmg_pkg::ST_RDDATA;
					end
				end
			end
			rgbmg_pkg::ST_SQ: begin
				cnt_d = '0;
				state_d = rgbmg_pkg::ST_SQRT;
			end
			rgbmg_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'(rgbmg_pkg::SQRT_STEPS - 1)) state_d = rgbmg_pkg::ST_STORE;
			end
			rgbmg_pkg::ST_STORE: begin
				cmd.store = 1'b1;
				state_d = rgbmg_pkg::ST_IDLE;
			end
			rgbmg_pkg::ST_RDADDR: state_d = rgbmg_pkg::ST_RDDATA;
			rgbmg_pkg::ST_RDDATA: begin
				cmd.rd_data = 1'b1;
				state_d = rgbmg_pkg::ST_MUL;
			end
			rgbmg_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d = '0;
				state_d = rgbmg_pkg::ST_DIV;
			end
			rgbmg_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'(rgbmg_pkg::DIV_STEPS - 1)) state_d = rgbmg_pkg::ST_FINISH;
			end
			rgbmg_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d = rgbmg_pkg::ST_OUT;
			end
			rgbmg_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.out_take = 1'b1;
					state_d = rgbmg_pkg::ST_IDLE;
				end
			end
			default: state_d = rgbmg_pkg::ST_IDLE;
		endcase
	end
endmodule

// ===== rtl/core/rgbmg_dp.sv =====
// rgbmg_dp: magnitude store, bitwise square root, restoring divider, frame counters
// depends on rgbmg_pkg
`timescale 1ns / 1ps
module rgbmg_dp #(
	parameter int MAX_PIXELS = rgbmg_pkg::MAX_PIXELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input rgbmg_pkg::in_item_t in_item,
	input logic [7:0] bright,
	input logic invert,
	input rgbmg_pkg::cmd_t cmd,
	output rgbmg_pkg::sts_t sts,
	output rgbmg_pkg::out_item_t out_item
);
	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CW = $clog2(MAX_PIXELS + 1);
	localparam int MW = rgbmg_pkg::MAG_W;
	localparam int NW = rgbmg_pkg::NUM_W;

	logic [MW-1:0] mem [MAX_PIXELS];
	logic [CW-1:0] count_q, rptr_q;
	logic [MW-1:0] peak_q;
	logic closed_q;
	logic fe_q;

	// square root: 34-bit radicand, one result bit per step
	logic [rgbmg_pkg::SQ_W-1:0] rad_q;
	logic [MW:0] rem_q;
	logic [MW-1:0] root_q;
	logic [MW+3:0] trial;
	logic [MW+2:0] rem_sh;

	// divider
	logic [NW-1:0] num_q;
	logic [MW:0] drem_q;
	logic [15:0] quo_q;
	logic [MW+1:0] dtrial;
	logic [MW-1:0] v_q;
	logic [15:0] gray_q;
	logic last_q;
	logic [15:0] full;
	logic [17:0] r2, g2, b2;
	logic [NW-1:0] prod;

	assign full = {bright, 8'd0};
	assign r2 = 18'(in_item.red) * 18'(in_item.red);
	assign g2 = 18'(in_item.green) * 18'(in_item.green);
	assign b2 = 18'(in_item.blue) * 18'(in_item.blue);
	assign prod = NW'(full) * NW'(v_q);

	assign rem_sh = {rem_q, rad_q[rgbmg_pkg::SQ_W-1 -: 2]};
	assign trial = {1'b0, rem_sh} - {2'b0, root_q, 2'b01};

	assign dtrial = {1'b0, drem_q[MW-1:0], num_q[NW-1]} - {2'b0, peak_q};

	// top 16 product bits are below peak since v <= peak, so 17 steps cover the quotient
	always_ff @(posedge clk) begin
		if (cmd.start_sq) begin
			rad_q <= 34'({18'(r2) + 18'(g2) + 18'(b2), 16'd0});
			rem_q <= '0;
			root_q <= '0;
			fe_q <= in_item.frame_end;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[rgbmg_pkg::SQ_W-3:0], 2'b00};
			if (!trial[MW+3]) begin
				rem_q <= trial[MW:0];
				root_q <= {root_q[MW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[MW:0];
				root_q <= {root_q[MW-2:0], 1'b0};
			end
		end
		if (cmd.store && count_q != CW'(MAX_PIXELS)) mem[count_q[AW-1:0]] <= root_q;
		if (cmd.rd_addr) last_q <= (rptr_q + CW'(1)) == count_q;
		if (cmd.rd_data) v_q <= mem[rptr_q[AW-1:0]];
		if (cmd.mul) begin
			num_q <= {prod[16:0], 16'd0};
			drem_q <= {2'b0, prod[NW-1:17]};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (!dtrial[MW+1]) begin
				drem_q <= dtrial[MW:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				drem_q <= {drem_q[MW-1:0], num_q[NW-1]};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			if (peak_q == '0) gray_q <= '0;
			else if (invert) gray_q <= full - quo_q;
			else gray_q <= quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rptr_q <= '0;
			peak_q <= '0;
			closed_q <= 1'b0;
		end else begin
			if (cmd.start_sq && cmd.new_frame) begin
				count_q <= '0;
				rptr_q <= '0;
				peak_q <= '0;
				closed_q <= 1'b0;
			end
			if (cmd.store) begin
				if (count_q != CW'(MAX_PIXELS)) begin
					count_q <= count_q + CW'(1);
					if (root_q > peak_q) peak_q <= root_q;
				end
				if (fe_q) closed_q <= 1'b1;
			end
			if (cmd.rd_data) rptr_q <= rptr_q + CW'(1);
		end
	end

	assign sts.frame_closed = closed_q;
	assign sts.can_read = closed_q && (rptr_q < count_q);
	assign out_item.gray_value = gray_q;
	assign out_item.last_pixel = last_q;
endmodule

// ===== rtl/core/rgb_magnitude_gray_normalize_core.sv =====
// rgb_magnitude_gray_normalize_core: top level, config registers, controller and datapath
// depends on rgbmg_pkg, rgbmg_ctrl, rgbmg_dp
// load item: 17 square root steps; read item: 17 divide steps before the result
// one item at a time; the next is taken once the current one is done (for a read, once its result is delivered)
// reads that give no result are accepted at the input and dropped; loads are accepted then run internally
// async active-low reset clears counters, peak, frame state and config to defaults
`timescale 1ns / 1ps
module rgb_magnitude_gray_normalize_core #(
	parameter int MAX_PIXELS = rgbmg_pkg::MAX_PIXELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input rgbmg_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output rgbmg_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [7:0] cfg_data
);
	logic [7:0] bright_q;
	logic invert_q;
	rgbmg_pkg::cmd_t cmd;
	rgbmg_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= rgbmg_pkg::BRIGHT_RST;
			invert_q <= rgbmg_pkg::INVERT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rgbmg_pkg::REG_BRIGHT: bright_q <= cfg_data;
				rgbmg_pkg::REG_INVERT: invert_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rgbmg_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_op(in_data.operation),
		.out_ready(out_ready),
		.sts(sts),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.cmd(cmd)
	);

	rgbmg_dp #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_data),
		.bright(bright_q),
		.invert(invert_q),
		.cmd(cmd),
		.sts(sts),
		.out_item(out_data)
	);
endmodule
